@@ src/gm_pkg.sv @@
// ----------------------------------------------------------------------------
// gm_pkg: shared types and helpers for the greedy rectangle mesher
// Request and result layouts, window setup, state codes, bit-search functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gm_pkg;

  localparam int MaxWidth = 64;
  localparam int MaxDepth = 64;
  localparam int AddrW    = $clog2(MaxDepth);
  localparam int CoordW   = 7;

  // scan pass codes
  localparam logic [2:0] PASS_RECT  = 3'd0;
  localparam logic [2:0] PASS_WEST  = 3'd1;
  localparam logic [2:0] PASS_NORTH = 3'd2;
  localparam logic [2:0] PASS_EAST  = 3'd3;
  localparam logic [2:0] PASS_SOUTH = 3'd4;
  localparam logic [2:0] PASS_DONE  = 3'd5;

  // configuration register indexes
  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_DEPTH = 1'b1;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    KIND_ACK   = 3'd0,
    KIND_RECT  = 3'd1,
    KIND_WEST  = 3'd2,
    KIND_NORTH = 3'd3,
    KIND_EAST  = 3'd4,
    KIND_SOUTH = 3'd5,
    KIND_DONE  = 3'd6
  } kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_R_CHK,
    S_R_NBR,
    S_R_DATA,
    S_R_FIND,
    S_R_END,
    S_G_CHK,
    S_G_DATA,
    S_C_CHK,
    S_C_DATA
  } state_e;

  typedef struct packed {
    op_e                 operation;
    logic [MaxWidth-1:0] row_bits;
  } req_t;

  typedef struct packed {
    kind_e             kind;
    logic [CoordW-1:0] x_lo;
    logic [CoordW-1:0] x_hi;
    logic [CoordW-1:0] z_lo;
    logic [CoordW-1:0] z_hi;
  } res_t;

  // clamped window and column mask
  typedef struct packed {
    logic [CoordW-1:0]   eff_w;
    logic [CoordW-1:0]   eff_d;
    logic [MaxWidth-1:0] wmask;
  } cfg_t;

  // index of lowest set bit (word of MaxWidth+1 bits)
  function automatic logic [CoordW-1:0] first_one(input logic [MaxWidth:0] v);
    logic [CoordW-1:0] r;
    r = '0;
    for (int i = MaxWidth; i >= 0; i--) begin
      if (v[i]) r = CoordW'(i);
    end
    return r;
  endfunction

  // ones at bit positions >= x
  function automatic logic [MaxWidth-1:0] mask_from(input logic [CoordW-1:0] x);
    logic [MaxWidth-1:0] m;
    for (int i = 0; i < MaxWidth; i++) begin
      m[i] = (CoordW'(i) >= x);
    end
    return m;
  endfunction

endpackage

@@ src/gm_ram.sv @@
// ----------------------------------------------------------------------------
// gm_ram: single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; read data appears in the cycle after the read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gm_ram #(
  parameter int Width = 64,
  parameter int Depth = 64,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/gm_ctrl.sv @@
// ----------------------------------------------------------------------------
// gm_ctrl: scan sequencer around the occupancy and used-mark memories
// Loads rows, then walks the bitmap one row or one cell per read to hand
// out rectangles and edge runs, marking covered cells by read-modify-write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  gm_pkg::req_t  req_i,
  input  gm_pkg::cfg_t  cfg_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output gm_pkg::res_t  res_o
);

  localparam int W  = gm_pkg::MaxWidth;
  localparam int AW = gm_pkg::AddrW;
  localparam int CW = gm_pkg::CoordW;

  gm_pkg::state_e state_q, state_d;
  logic [2:0]     pass_q, pass_d;
  logic [CW-1:0]  x_q, x_d, z_q, z_d;
  logic [CW-1:0]  ez_q, ez_d, ex_q, ex_d, x0_q, x0_d, zs_q, zs_d;
  logic [CW-1:0]  rows_q, rows_d;
  logic           in_run_q, in_run_d;
  logic [W-1:0]   e_q, e_d, run_q, run_d, nbr_q, nbr_d, urow_q, urow_d;
  logic [W:0]     endb_q, endb_d;
  logic [W-1:0]   uvalid_q;
  logic           uv_rd_q;
  logic           res_valid_q, res_valid_d;
  gm_pkg::res_t   res_q, res_d;

  // memory controls
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           occ_we, used_we, clear_used;
  logic [AW-1:0]  occ_waddr, used_waddr;
  logic [W-1:0]   occ_wdata, used_wdata;
  logic [W-1:0]   occ_rdata, used_rdata;

  // scratch values
  logic [W-1:0]   m, u, e, lsb;
  logic [W:0]     sum;
  logic [CW-1:0]  ex, load_addr;
  logic           col_bit;

  gm_ram #(.Width(W), .Depth(gm_pkg::MaxDepth)) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wdata_i (occ_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (occ_rdata)
  );

  gm_ram #(.Width(W), .Depth(gm_pkg::MaxDepth)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (used_rdata)
  );

  // row valid bits for used marks; an invalid row reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uvalid_q <= '0;
      uv_rd_q  <= 1'b0;
    end else begin
      if (clear_used) begin
        uvalid_q <= '0;
      end else if (used_we) begin
        uvalid_q[used_waddr] <= 1'b1;
      end
      if (rd_en) begin
        uv_rd_q <= uvalid_q[rd_addr];
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gm_pkg::S_IDLE;
      pass_q      <= gm_pkg::PASS_RECT;
      x_q         <= '0;
      z_q         <= '0;
      rows_q      <= '0;
      in_run_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      x_q         <= x_d;
      z_q         <= z_d;
      rows_q      <= rows_d;
      in_run_q    <= in_run_d;
      res_valid_q <= res_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    ez_q   <= ez_d;
    ex_q   <= ex_d;
    x0_q   <= x0_d;
    zs_q   <= zs_d;
    e_q    <= e_d;
    run_q  <= run_d;
    nbr_q  <= nbr_d;
    urow_q <= urow_d;
    endb_q <= endb_d;
    res_q  <= res_d;
  end

  // next state and outputs
  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    x_d         = x_q;
    z_d         = z_q;
    ez_d        = ez_q;
    ex_d        = ex_q;
    x0_d        = x0_q;
    zs_d        = zs_q;
    rows_d      = rows_q;
    in_run_d    = in_run_q;
    e_d         = e_q;
    run_d       = run_q;
    nbr_d       = nbr_q;
    urow_d      = urow_q;
    endb_d      = endb_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    rd_en       = 1'b0;
    rd_addr     = z_q[AW-1:0];
    occ_we      = 1'b0;
    occ_waddr   = '0;
    occ_wdata   = req_i.row_bits;
    used_we     = 1'b0;
    used_waddr  = z_q[AW-1:0];
    used_wdata  = urow_q | run_q;
    clear_used  = 1'b0;

    m       = occ_rdata & cfg_i.wmask;
    u       = uv_rd_q ? used_rdata : '0;
    e       = '0;
    lsb     = e_q & (~e_q + W'(1));
    sum     = {1'b0, e_q} + {1'b0, lsb};
    ex      = gm_pkg::first_one(endb_q);
    col_bit = 1'b0;
    load_addr = (rows_q >= cfg_i.eff_d) ? '0 : rows_q;

    case (state_q)
      gm_pkg::S_IDLE: begin
        if (start_i) begin
          if (req_i.operation == gm_pkg::OP_LOAD) begin
            // store row unless the depth is zero, restart the scan
            if (cfg_i.eff_d != '0) begin
              occ_we    = 1'b1;
              occ_waddr = load_addr[AW-1:0];
              rows_d    = load_addr + CW'(1);
            end
            clear_used  = 1'b1;
            pass_d      = gm_pkg::PASS_RECT;
            x_d         = '0;
            z_d         = '0;
            res_valid_d = 1'b1;
            res_d       = '{gm_pkg::KIND_ACK, '0, '0, '0, '0};
          end else begin
            state_d = gm_pkg::S_DISPATCH;
          end
        end
      end

      gm_pkg::S_DISPATCH: begin
        in_run_d = 1'b0;
        if (pass_q == gm_pkg::PASS_DONE) begin
          res_valid_d = 1'b1;
          res_d       = '{gm_pkg::KIND_DONE, '0, '0, '0, '0};
          state_d     = gm_pkg::S_IDLE;
        end else if (pass_q == gm_pkg::PASS_WEST || pass_q == gm_pkg::PASS_EAST) begin
          state_d = gm_pkg::S_C_CHK;
        end else begin
          state_d = gm_pkg::S_R_CHK;
        end
      end

      // row-major passes: fetch neighbor row if needed, then current row
      gm_pkg::S_R_CHK: begin
        nbr_d = '0;
        if (z_q >= cfg_i.eff_d) begin
          pass_d  = pass_q + 3'd1;
          x_d     = '0;
          z_d     = '0;
          state_d = gm_pkg::S_DISPATCH;
        end else if (pass_q == gm_pkg::PASS_NORTH && z_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = AW'(z_q - CW'(1));
          state_d = gm_pkg::S_R_NBR;
        end else if (pass_q == gm_pkg::PASS_SOUTH && (z_q + CW'(1)) < cfg_i.eff_d) begin
          rd_en   = 1'b1;
          rd_addr = AW'(z_q + CW'(1));
          state_d = gm_pkg::S_R_NBR;
        end else begin
          rd_en   = 1'b1;
          state_d = gm_pkg::S_R_DATA;
        end
      end

      gm_pkg::S_R_NBR: begin
        nbr_d   = m;
        rd_en   = 1'b1;
        state_d = gm_pkg::S_R_DATA;
      end

      gm_pkg::S_R_DATA: begin
        if (pass_q == gm_pkg::PASS_RECT) begin
          e = m & ~u;
        end else begin
          e = m & ~nbr_q;
        end
        e_d     = e & gm_pkg::mask_from(x_q);
        urow_d  = u;
        state_d = gm_pkg::S_R_FIND;
      end

      // isolate the first run of candidate cells in the row
      gm_pkg::S_R_FIND: begin
        if (e_q == '0) begin
          z_d     = z_q + CW'(1);
          x_d     = '0;
          state_d = gm_pkg::S_R_CHK;
        end else begin
          x0_d    = gm_pkg::first_one({1'b0, e_q});
          run_d   = e_q & ~sum[W-1:0];
          endb_d  = sum & ~{1'b0, e_q};
          state_d = gm_pkg::S_R_END;
        end
      end

      gm_pkg::S_R_END: begin
        if (pass_q == gm_pkg::PASS_RECT) begin
          used_we = 1'b1;
          ex_d    = ex;
          ez_d    = z_q + CW'(1);
          state_d = gm_pkg::S_G_CHK;
        end else begin
          x_d         = ex;
          res_valid_d = 1'b1;
          res_d = '{gm_pkg::kind_e'(pass_q + 3'd1), x0_q, ex, z_q, z_q + CW'(1)};
          state_d     = gm_pkg::S_IDLE;
        end
      end

      // grow the rectangle downward row by row
      gm_pkg::S_G_CHK: begin
        if (ez_q >= cfg_i.eff_d) begin
          x_d         = ex_q;
          res_valid_d = 1'b1;
          res_d       = '{gm_pkg::KIND_RECT, x0_q, ex_q, z_q, ez_q};
          state_d     = gm_pkg::S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ez_q[AW-1:0];
          state_d = gm_pkg::S_G_DATA;
        end
      end

      gm_pkg::S_G_DATA: begin
        if (((m & ~u) & run_q) == run_q) begin
          used_we    = 1'b1;
          used_waddr = ez_q[AW-1:0];
          used_wdata = u | run_q;
          ez_d       = ez_q + CW'(1);
          state_d    = gm_pkg::S_G_CHK;
        end else begin
          x_d         = ex_q;
          res_valid_d = 1'b1;
          res_d       = '{gm_pkg::KIND_RECT, x0_q, ex_q, z_q, ez_q};
          state_d     = gm_pkg::S_IDLE;
        end
      end

      // column-major passes: one cell per row read
      gm_pkg::S_C_CHK: begin
        if (x_q >= cfg_i.eff_w) begin
          pass_d  = pass_q + 3'd1;
          x_d     = '0;
          z_d     = '0;
          state_d = gm_pkg::S_DISPATCH;
        end else if (z_q >= cfg_i.eff_d) begin
          if (in_run_q) begin
            res_valid_d = 1'b1;
            res_d = '{gm_pkg::kind_e'(pass_q + 3'd1), x_q, x_q + CW'(1), zs_q, z_q};
            state_d     = gm_pkg::S_IDLE;
          end else begin
            x_d = x_q + CW'(1);
            z_d = '0;
          end
        end else begin
          rd_en   = 1'b1;
          state_d = gm_pkg::S_C_DATA;
        end
      end

      gm_pkg::S_C_DATA: begin
        if (pass_q == gm_pkg::PASS_WEST) begin
          e = m & ~(m << 1);
        end else begin
          e = m & ~(m >> 1);
        end
        col_bit = e[x_q[AW-1:0]];
        if (in_run_q && !col_bit) begin
          res_valid_d = 1'b1;
          res_d = '{gm_pkg::kind_e'(pass_q + 3'd1), x_q, x_q + CW'(1), zs_q, z_q};
          state_d     = gm_pkg::S_IDLE;
        end else begin
          if (!in_run_q && col_bit) begin
            in_run_d = 1'b1;
            zs_d     = z_q;
          end
          z_d     = z_q + CW'(1);
          state_d = gm_pkg::S_C_CHK;
        end
      end

      default: begin
        state_d = gm_pkg::S_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != gm_pkg::S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // every fetch ends with exactly one result as the sequencer returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gm_pkg::S_IDLE && $past(state_q) != gm_pkg::S_IDLE) |-> res_valid_q)
    else $error("fetch finished without a result");

  // faces and runs are never empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.kind != gm_pkg::KIND_ACK && res_q.kind != gm_pkg::KIND_DONE)
    |-> (res_q.x_hi > res_q.x_lo && res_q.z_hi > res_q.z_lo))
    else $error("empty face emitted");

  // used-mark update never collides with a memory read
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(used_we && rd_en))
    else $error("used-mark write overlaps a read");

  // scan pass stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni) pass_q <= gm_pkg::PASS_DONE)
    else $error("scan pass out of range");
`endif

endmodule

@@ src/greedy_rectangle_mesher.sv @@
// ----------------------------------------------------------------------------
// greedy_rectangle_mesher: occupancy bitmap to rectangles and edge runs
//
//   channel   handshake                 payload
//   request   start_i / busy_o          req_i   (operation, row_bits)
//   result    res_valid_o (1 cycle)     res_o   (kind, x_lo, x_hi, z_lo, z_hi)
//   config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A load is handled in the idle state; its ack appears the next cycle. A fetch
// reads the bitmap row by row (row-major passes) or one cell per row read
// (column-major passes), bounded by the single read port of the bitmap RAM.
// Reset clears the scan state; bitmap rows are undefined until loaded.
// Results cannot be stalled; config is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module greedy_rectangle_mesher (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  gm_pkg::req_t                       req_i,
  output logic                               res_valid_o,
  output gm_pkg::res_t                       res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_index_i,
  input  logic [gm_pkg::CoordW-1:0]          cfg_data_i
);

  localparam int CW = gm_pkg::CoordW;

  logic [CW-1:0] width_q, depth_q;
  gm_pkg::cfg_t  cfg;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= CW'(64);
      depth_q <= CW'(64);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == gm_pkg::CFG_WIDTH) begin
        width_q <= cfg_data_i;
      end else begin
        depth_q <= cfg_data_i;
      end
    end
  end

  assign cfg_ready_o = 1'b1;

  // clamp window and build column mask
  always_comb begin
    cfg.eff_w = (width_q > CW'(gm_pkg::MaxWidth)) ? CW'(gm_pkg::MaxWidth) : width_q;
    cfg.eff_d = (depth_q > CW'(gm_pkg::MaxDepth)) ? CW'(gm_pkg::MaxDepth) : depth_q;
    for (int i = 0; i < gm_pkg::MaxWidth; i++) begin
      cfg.wmask[i] = (CW'(i) < cfg.eff_w);
    end
  end

  gm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .req_i       (req_i),
    .cfg_i       (cfg),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for greedy_rectangle_mesher
// Loads occupancy rows and fetches faces under a range of window settings.
// Every result is checked against an in-bench mesher model or a typed expectation
// of the directed table, with random request gaps and the directed table first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import gm_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  req_t              req_i;
  logic              res_valid_o;
  res_t              res_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic              cfg_index_i;
  logic [CoordW-1:0] cfg_data_i;

  greedy_rectangle_mesher dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .res_valid_o, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // clock: 12 ns period
  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  // mesher model state
  logic [63:0] occ_rows [64];
  logic [63:0] used_rows [64];
  logic [6:0]  win_w, win_d;
  int          rows_in;
  logic [2:0]  pass_q;
  int          pos_x, pos_z;

  res_t face_q [$];
  int   errors;
  int   items;
  bit   quiet;

  function automatic int eff_w();
    return (win_w > 64) ? 64 : int'(win_w);
  endfunction

  function automatic int eff_d();
    return (win_d > 64) ? 64 : int'(win_d);
  endfunction

  function automatic bit filled(int x, int z);
    if (x < 0 || z < 0 || x >= eff_w() || z >= eff_d()) return 1'b0;
    return occ_rows[z][x];
  endfunction

  function automatic bit free_cell(int x, int z);
    if (!filled(x, z)) return 1'b0;
    return !used_rows[z][x];
  endfunction

  function automatic res_t mk_res(kind_e k, int xl, int xh, int zl, int zh);
    res_t r;
    r.kind = k;
    r.x_lo = CoordW'(xl);
    r.x_hi = CoordW'(xh);
    r.z_lo = CoordW'(zl);
    r.z_hi = CoordW'(zh);
    return r;
  endfunction

  // next greedy rectangle from the stored scan position
  function automatic bit find_rect(output res_t r);
    int w, d, x, ex, ez;
    bit ok;
    w = eff_w();
    d = eff_d();
    for (int z = pos_z; z < d; z++) begin
      for (x = (z == pos_z) ? pos_x : 0; x < w; x++) begin
        if (!free_cell(x, z)) continue;
        ex = x + 1;
        while (ex < w && free_cell(ex, z)) ex++;
        for (ez = z + 1; ez < d; ez++) begin
          ok = 1'b1;
          for (int ix = x; ix < ex; ix++) ok = ok && free_cell(ix, ez);
          if (!ok) break;
        end
        for (int iz = z; iz < ez; iz++)
          for (int ix = x; ix < ex; ix++) used_rows[iz][ix] = 1'b1;
        pos_z = z;
        pos_x = ex;
        r = mk_res(KIND_RECT, x, ex, z, ez);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // next edge run of one side pass
  function automatic bit find_edge(logic [2:0] p, output res_t r);
    bit colmaj;
    int dx, dz, olim, ilim, so, si, i, st, x, z;
    colmaj = (p == PASS_WEST || p == PASS_EAST);
    dx = (p == PASS_WEST) ? -1 : (p == PASS_EAST) ? 1 : 0;
    dz = (p == PASS_NORTH) ? -1 : (p == PASS_SOUTH) ? 1 : 0;
    olim = colmaj ? eff_w() : eff_d();
    ilim = colmaj ? eff_d() : eff_w();
    so = colmaj ? pos_x : pos_z;
    si = colmaj ? pos_z : pos_x;
    for (int o = so; o < olim; o++) begin
      i = (o == so) ? si : 0;
      while (i < ilim) begin
        x = colmaj ? o : i;
        z = colmaj ? i : o;
        if (!filled(x, z) || filled(x + dx, z + dz)) begin
          i++;
          continue;
        end
        st = i;
        i++;
        while (i < ilim) begin
          x = colmaj ? o : i;
          z = colmaj ? i : o;
          if (!filled(x, z) || filled(x + dx, z + dz)) break;
          i++;
        end
        if (colmaj) begin
          pos_x = o; pos_z = i;
          r = mk_res(kind_e'(p + 3'd1), o, o + 1, st, i);
        end else begin
          pos_z = o; pos_x = i;
          r = mk_res(kind_e'(p + 3'd1), st, i, o, o + 1);
        end
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // advance the model by one request and return its face
  function automatic res_t mesh_step(req_t rq);
    res_t r;
    if (rq.operation == OP_LOAD) begin
      if (eff_d() > 0) begin
        if (rows_in >= eff_d()) rows_in = 0;
        occ_rows[rows_in] = rq.row_bits;
        rows_in++;
      end
      foreach (used_rows[k]) used_rows[k] = '0;
      pass_q = PASS_RECT;
      pos_x = 0;
      pos_z = 0;
      return mk_res(KIND_ACK, 0, 0, 0, 0);
    end
    while (pass_q < PASS_DONE) begin
      if (pass_q == PASS_RECT) begin
        if (find_rect(r)) return r;
      end else if (find_edge(pass_q, r)) begin
        return r;
      end
      pass_q++;
      pos_x = 0;
      pos_z = 0;
    end
    return mk_res(KIND_DONE, 0, 0, 0, 0);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && res_valid_o) begin
      if (face_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, res_o);
        errors++;
      end else begin
        e = face_q.pop_front();
        if (res_o.kind !== e.kind || res_o.x_lo !== e.x_lo || res_o.x_hi !== e.x_hi ||
            res_o.z_lo !== e.z_lo || res_o.z_hi !== e.z_hi) begin
          $display("%0t: mismatch, expected %p, actual %p", $time, e, res_o);
          errors++;
        end
      end
    end
  end

  // send one request; typed expectation overrides the model's face
  task automatic send_req(op_e op, logic [63:0] bits, bit typed, res_t exp_r,
                          output res_t got);
    req_t rq;
    int gap;
    rq.operation = op;
    rq.row_bits = bits;
    start_i <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy_o);
    got = mesh_step(rq);
    face_q.push_back(typed ? exp_r : got);
    items++;
    gap = (!quiet && $urandom_range(99) < 34) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // wait until every expected face has arrived
  task automatic drain();
    start_i <= 1'b0;
    while (face_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [6:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_WIDTH) win_w = val;
    else win_d = val;
    if ($urandom_range(1)) repeat ($urandom_range(1, 3)) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_row();
    logic [63:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return a & b;
      1: return a | b;
      2: return '1;
      3: return '0;
      default: return a;
    endcase
  endfunction

  // directed table
  typedef struct {
    op_e         op;
    logic [63:0] bits;
    bit          typed;
    res_t        exp_r;
  } dir_row_t;

  dir_row_t dir_tab [$];

  function automatic dir_row_t row_of(op_e op, logic [63:0] bits, bit typed, res_t e);
    dir_row_t d;
    d.op = op; d.bits = bits; d.typed = typed; d.exp_r = e;
    return d;
  endfunction

  initial begin
    res_t ack, done_r, got, none;
    int fcnt, lim;
    logic [6:0] wv, dv;
    errors = 0;
    items = 0;
    quiet = 1'b0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_WIDTH;
    cfg_data_i = '0;
    win_w = 7'd64;
    win_d = 7'd64;
    rows_in = 0;
    pass_q = PASS_RECT;
    pos_x = 0;
    pos_z = 0;
    foreach (used_rows[k]) used_rows[k] = '0;
    foreach (occ_rows[k]) occ_rows[k] = '0;
    ack = mk_res(KIND_ACK, 0, 0, 0, 0);
    done_r = mk_res(KIND_DONE, 0, 0, 0, 0);
    none = ack;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: full-width window two rows deep, corner bits, wrap, done
    write_cfg(CFG_WIDTH, 7'd64);
    write_cfg(CFG_DEPTH, 7'd2);
    dir_tab.push_back(row_of(OP_LOAD, '1, 1, ack));
    dir_tab.push_back(row_of(OP_LOAD, 64'h8000_0000_0000_0001, 1, ack));
    dir_tab.push_back(row_of(OP_FETCH, '0, 1, mk_res(KIND_RECT, 0, 64, 0, 1)));
    for (int k = 0; k < 10; k++) dir_tab.push_back(row_of(OP_FETCH, '0, 0, none));
    for (int k = 0; k < 3; k++) dir_tab.push_back(row_of(OP_FETCH, '1, 1, done_r));
    // third load wraps to row 0 and restarts the scan
    dir_tab.push_back(row_of(OP_LOAD, 64'h0000_0000_0000_00F0, 1, ack));
    dir_tab.push_back(row_of(OP_FETCH, '0, 1, mk_res(KIND_RECT, 4, 8, 0, 1)));
    dir_tab.push_back(row_of(OP_FETCH, '0, 0, none));
    dir_tab.push_back(row_of(OP_FETCH, '0, 0, none));
    dir_tab.push_back(row_of(OP_LOAD, '0, 1, ack));
    foreach (dir_tab[k]) send_req(dir_tab[k].op, dir_tab[k].bits, dir_tab[k].typed,
                                  dir_tab[k].exp_r, got);
    drain();

    // fill every row of the full window so later fetches never read stale rows
    write_cfg(CFG_DEPTH, 7'd64);
    for (int k = 0; k < 64; k++) send_req(OP_LOAD, rand_row(), 0, none, got);
    for (int k = 0; k < 30; k++) send_req(OP_FETCH, '0, 0, none, got);
    drain();

    // random phases
    for (int ph = 0; items < 900; ph++) begin
      quiet = (ph >= 4 && ph < 8);
      case ($urandom_range(9))
        0: wv = 7'd64;
        1: wv = 7'd1;
        2: wv = 7'd127;
        3: wv = (ph % 5 == 0) ? 7'd0 : 7'd33;
        default: wv = 7'($urandom_range(1, 16));
      endcase
      case ($urandom_range(9))
        0: dv = (ph % 3 == 0) ? 7'd64 : 7'd20;
        1: dv = 7'd1;
        2: dv = (ph % 7 == 0) ? 7'd100 : 7'd2;
        3: dv = (ph % 11 == 0) ? 7'd0 : 7'd3;
        default: dv = 7'($urandom_range(1, 8));
      endcase
      if ($urandom_range(1)) begin
        write_cfg(CFG_WIDTH, wv);
        write_cfg(CFG_DEPTH, dv);
      end else begin
        write_cfg(CFG_DEPTH, dv);
        write_cfg(CFG_WIDTH, wv);
      end
      // load the window, sometimes short or long to exercise the wrap
      lim = eff_d() + $urandom_range(0, 2) - 1;
      if (lim < 1) lim = 1;
      if (lim > 12 && $urandom_range(3) != 0) lim = 12;
      for (int k = 0; k < lim; k++) send_req(OP_LOAD, rand_row(), 0, none, got);
      // fetch faces to done, with a stray load now and then
      fcnt = 0;
      lim = (eff_w() * eff_d() > 200) ? 120 : 400;
      do begin
        if ($urandom_range(99) < 3) begin
          send_req(OP_LOAD, rand_row(), 0, none, got);
          got = ack;
        end else begin
          send_req(OP_FETCH, {$urandom, $urandom}, 0, none, got);
        end
        fcnt++;
        if (ph == 2 && fcnt == 5) drain();
      end while (got.kind != KIND_DONE && fcnt < lim && items < 950);
      repeat ($urandom_range(0, 2)) send_req(OP_FETCH, '0, 0, none, got);
      // settings change mid-scan between phases as well
      drain();
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && face_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #200ms;
    $display("Verification failed");
    $finish;
  end

endmodule

@@ greedy_rectangle_mesher.f @@
src/gm_pkg.sv
src/gm_ram.sv
src/gm_ctrl.sv
src/greedy_rectangle_mesher.sv
bench/tb_top.sv
